// ----- design/dense_dijkstra_shortest_paths_top_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef DENSE_DIJKSTRA_SHORTEST_PATHS_TOP_MACROS_SVH
`define DENSE_DIJKSTRA_SHORTEST_PATHS_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define DD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dd assertion failed");

// Check cons in the cycle after ante.
`define DD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dd assertion failed");

`endif

// ----- design/dd_pkg.sv -----
package dd_pkg;

    localparam int DIST_W = 20;
    localparam logic [DIST_W-1:0] NO_EDGE = 20'd1000000;
    localparam logic [6:0] NODE_COUNT_RESET = 7'd64;

    localparam logic [1:0] REQ_ADD_EDGE = 2'd0;
    localparam logic [1:0] REQ_MARK     = 2'd1;
    localparam logic [1:0] REQ_RUN      = 2'd2;
    localparam logic [1:0] REQ_CLEAR    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_EDGE_RD,
        ST_EDGE_CMP,
        ST_EDGE_WR_BA,
        ST_RELAX,
        ST_RELAX_LAST,
        ST_PICK,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DIST_W-1:0] a;
        logic [DIST_W-1:0] b;
        logic [DIST_W-1:0] c;
        logic [DIST_W-1:0] best;
    } alu_in_t;

    typedef struct packed {
        logic [DIST_W:0]   sum;
        logic              less;
        logic [DIST_W-1:0] new_val;
        logic              better;
    } alu_out_t;

endpackage

// ----- design/dd_ram.sv -----
module dd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/dd_alu.sv -----
module dd_alu (
    input  dd_pkg::alu_in_t  op,
    output dd_pkg::alu_out_t res
);

    always_comb
    begin
        res.sum     = {1'b0, op.a} + {1'b0, op.b};
        res.less    = res.sum < {1'b0, op.c};
        res.new_val = res.less ? res.sum[dd_pkg::DIST_W-1:0] : op.c;
        res.better  = res.new_val < op.best;
    end

endmodule

// ----- design/dense_dijkstra_shortest_paths_top.sv -----
// In a run each visited node streams one matrix row through the shared add/compare unit,
// one entry per cycle, then a final pass over the distance memory checks the targets.
// After reset a clearing pass writes "no edge" into all MAX_NODES^2 matrix entries and drops
// the targets, one per cycle (4096 at the default size); no item is accepted until it ends.
module dense_dijkstra_shortest_paths_top #(
    parameter int MAX_NODES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [5:0]  node_a,
    input  logic [5:0]  node_b,
    input  logic [15:0] weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        all_reached,
    output logic [19:0] longest_distance
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = NW + 1;
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW = $clog2(DEPTH);
    localparam int DW = dd_pkg::DIST_W;
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_NODES);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
    localparam logic [NW-1:0] SCAN_LAST_IDX = NW'(MAX_NODES - 1);

    dd_pkg::state_t state_reg, state_next;

    logic [6:0]           node_count_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic                 pipe_valid_reg;
    logic                 out_valid_reg;

    logic [NW-1:0] a_reg, b_reg, start_reg, cur_reg, next_reg, j_reg, pipe_j_reg;
    logic [15:0]   w_reg;
    logic [CW-1:0] n_reg;
    logic [DW-1:0] dcur_reg, best_reg, longest_reg, out_longest_reg;
    logic          first_reg, found_reg, all_reg, out_all_reg;

    logic [CW-1:0] n_now;
    logic          a_ok, b_ok, start_ok, accept, slot_free;
    logic          issue, last_issue, relax_mode, proc_relax, proc_scan;
    logic          vis_now, scan_vis;
    logic [NW-1:0] j_end;
    logic [AW-1:0] ab_addr, ba_addr, row_addr;

    logic          edge_we, dist_we, tgt_we;
    logic [AW-1:0] edge_waddr, edge_raddr;
    logic [DW-1:0] edge_wdata, edge_rdata;
    logic [NW-1:0] dist_waddr, tgt_waddr;
    logic [DW:0]   dist_wdata, dist_rdata;
    logic          tgt_wdata, tgt_rdata;

    dd_pkg::alu_in_t  alu_in;
    dd_pkg::alu_out_t alu_out;

    always_comb
    begin
        if (node_count_reg == 7'd0)
        begin
            n_now = CW'(1);
        end
        else if (int'(node_count_reg) > MAX_NODES)
        begin
            n_now = CW'(MAX_NODES);
        end
        else
        begin
            n_now = CW'(node_count_reg);
        end
    end

    assign a_ok      = int'(node_a) < MAX_NODES;
    assign b_ok      = int'(node_b) < MAX_NODES;
    assign start_ok  = int'(node_a) < int'(n_now);
    assign in_ready  = (state_reg == dd_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign ab_addr  = AW'(a_reg) * ROW_STRIDE + AW'(b_reg);
    assign ba_addr  = AW'(b_reg) * ROW_STRIDE + AW'(a_reg);
    assign row_addr = AW'(cur_reg) * ROW_STRIDE + AW'(j_reg);

    assign relax_mode = (state_reg == dd_pkg::ST_RELAX) || (state_reg == dd_pkg::ST_RELAX_LAST);
    assign issue      = (state_reg == dd_pkg::ST_RELAX) || (state_reg == dd_pkg::ST_SCAN);
    assign j_end      = (state_reg == dd_pkg::ST_RELAX) ? NW'(n_reg - CW'(1)) : SCAN_LAST_IDX;
    assign last_issue = issue && (j_reg == j_end);
    assign proc_relax = pipe_valid_reg && relax_mode;
    assign proc_scan  = pipe_valid_reg && !relax_mode;

    // the visited flag rides in the top bit of each distance entry; the first pass
    // rewrites every active entry, so before it only the start counts as visited
    assign vis_now  = first_reg ? (pipe_j_reg == start_reg) : dist_rdata[DW];
    assign scan_vis = dist_rdata[DW] && !first_reg && (CW'(pipe_j_reg) < n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        dd_pkg::REQ_ADD_EDGE:
                            state_next = (a_ok && b_ok) ? dd_pkg::ST_EDGE_RD : dd_pkg::ST_IDLE;
                        dd_pkg::REQ_RUN:
                            state_next = start_ok ? dd_pkg::ST_RELAX : dd_pkg::ST_SCAN;
                        dd_pkg::REQ_CLEAR:
                            state_next = dd_pkg::ST_CLEAR;
                        default:
                            state_next = dd_pkg::ST_IDLE;
                    endcase
                end
            end
            dd_pkg::ST_CLEAR:
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = dd_pkg::ST_IDLE;
                end
            dd_pkg::ST_EDGE_RD:
                state_next = dd_pkg::ST_EDGE_CMP;
            dd_pkg::ST_EDGE_CMP:
                state_next = alu_out.less ? dd_pkg::ST_EDGE_WR_BA : dd_pkg::ST_IDLE;
            dd_pkg::ST_EDGE_WR_BA:
                state_next = dd_pkg::ST_IDLE;
            dd_pkg::ST_RELAX:
                if (last_issue)
                begin
                    state_next = dd_pkg::ST_RELAX_LAST;
                end
            dd_pkg::ST_RELAX_LAST:
                state_next = dd_pkg::ST_PICK;
            dd_pkg::ST_PICK:
                state_next = found_reg ? dd_pkg::ST_RELAX : dd_pkg::ST_SCAN;
            dd_pkg::ST_SCAN:
                if (last_issue)
                begin
                    state_next = dd_pkg::ST_SCAN_LAST;
                end
            dd_pkg::ST_SCAN_LAST:
                state_next = dd_pkg::ST_DONE;
            dd_pkg::ST_DONE:
                if (slot_free)
                begin
                    state_next = dd_pkg::ST_IDLE;
                end
            default:
                state_next = dd_pkg::ST_IDLE;
        endcase
    end

    // memory and unit controls
    always_comb
    begin
        edge_we    = 1'b0;
        edge_waddr = ba_addr;
        edge_wdata = DW'(w_reg);
        edge_raddr = row_addr;
        alu_in.a   = dcur_reg;
        alu_in.b   = edge_rdata;
        alu_in.c   = dist_rdata[DW-1:0];
        alu_in.best = best_reg;
        case (state_reg)
            dd_pkg::ST_CLEAR:
            begin
                edge_we    = 1'b1;
                edge_waddr = clr_cnt_reg;
                edge_wdata = dd_pkg::NO_EDGE;
            end
            dd_pkg::ST_EDGE_RD:
                edge_raddr = ab_addr;
            dd_pkg::ST_EDGE_CMP:
            begin
                alu_in.a   = DW'(w_reg);
                alu_in.b   = '0;
                alu_in.c   = edge_rdata;
                edge_we    = alu_in.a < edge_rdata;
                edge_waddr = ab_addr;
            end
            dd_pkg::ST_EDGE_WR_BA:
                edge_we = 1'b1;
            dd_pkg::ST_SCAN, dd_pkg::ST_SCAN_LAST:
            begin
                // longest < dist flags a new maximum
                alu_in.a = longest_reg;
                alu_in.b = '0;
                alu_in.c = dist_rdata[DW-1:0];
            end
            default:
            begin
                // first pass: start holds 0, all others "no edge"
                if (first_reg)
                begin
                    alu_in.c = (pipe_j_reg == start_reg) ? '0 : dd_pkg::NO_EDGE;
                end
            end
        endcase
    end

    // distance and target memory controls
    always_comb
    begin
        dist_we    = proc_relax;
        dist_waddr = pipe_j_reg;
        dist_wdata = {vis_now, alu_out.new_val};
        tgt_we     = 1'b0;
        tgt_waddr  = NW'(node_a);
        tgt_wdata  = 1'b1;
        case (state_reg)
            dd_pkg::ST_IDLE:
                tgt_we = accept && (req_type == dd_pkg::REQ_MARK) && a_ok;
            dd_pkg::ST_CLEAR:
            begin
                // drop the targets during the first steps of the pass
                tgt_we    = int'(clr_cnt_reg) < MAX_NODES;
                tgt_waddr = NW'(clr_cnt_reg);
                tgt_wdata = 1'b0;
            end
            dd_pkg::ST_PICK:
            begin
                // mark the chosen node visited
                dist_we    = found_reg;
                dist_waddr = next_reg;
                dist_wdata = {1'b1, best_reg};
            end
            default:
                tgt_we = 1'b0;
        endcase
    end

    dd_alu u_alu (
        .op  (alu_in),
        .res (alu_out)
    );

    dd_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    dd_ram #(
        .WIDTH (DW + 1),
        .DEPTH (MAX_NODES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (j_reg),
        .rdata (dist_rdata)
    );

    dd_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NODES)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (tgt_waddr),
        .wdata (tgt_wdata),
        .raddr (j_reg),
        .rdata (tgt_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dd_pkg::ST_CLEAR;
            node_count_reg <= dd_pkg::NODE_COUNT_RESET;
            clr_cnt_reg    <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pipe_valid_reg <= issue;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (state_reg == dd_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            else
            begin
                clr_cnt_reg <= '0;
            end
            if (state_reg == dd_pkg::ST_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        pipe_j_reg <= j_reg;
        if (issue)
        begin
            j_reg <= last_issue ? '0 : j_reg + NW'(1);
        end
        if (accept)
        begin
            a_reg <= NW'(node_a);
            b_reg <= NW'(node_b);
            w_reg <= weight;
            if (req_type == dd_pkg::REQ_RUN)
            begin
                n_reg       <= n_now;
                start_reg   <= NW'(node_a);
                cur_reg     <= NW'(node_a);
                dcur_reg    <= '0;
                first_reg   <= 1'b1;
                best_reg    <= dd_pkg::NO_EDGE;
                found_reg   <= 1'b0;
                j_reg       <= '0;
                all_reg     <= 1'b1;
                longest_reg <= '0;
            end
        end
        if (proc_relax && !vis_now && alu_out.better)
        begin
            best_reg  <= alu_out.new_val;
            next_reg  <= pipe_j_reg;
            found_reg <= 1'b1;
        end
        if (state_reg == dd_pkg::ST_PICK)
        begin
            // advance to the closest unvisited node
            cur_reg   <= next_reg;
            dcur_reg  <= best_reg;
            first_reg <= 1'b0;
            best_reg  <= dd_pkg::NO_EDGE;
            found_reg <= 1'b0;
            j_reg     <= '0;
        end
        if (proc_scan && tgt_rdata)
        begin
            if (!scan_vis)
            begin
                all_reg <= 1'b0;
            end
            else if (alu_out.less)
            begin
                longest_reg <= dist_rdata[DW-1:0];
            end
        end
        if (state_reg == dd_pkg::ST_DONE && slot_free)
        begin
            out_all_reg     <= all_reg;
            out_longest_reg <= all_reg ? longest_reg : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign all_reached      = out_all_reg;
    assign longest_distance = out_longest_reg;

endmodule

// ----- design/dd_checker.sv -----
`include "dense_dijkstra_shortest_paths_top_macros.svh"

module dd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  req_type,
    input logic        out_valid,
    input logic        out_ready,
    input logic        all_reached,
    input logic [19:0] longest_distance
);

    // a stalled result word stays put
    `DD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(longest_distance) && $stable(all_reached))

    // run and clear keep the block busy afterwards
    `DD_ASSERT_NEXT(a_busy_after_long_req, clk, rst_n,
        in_valid && in_ready && (req_type == dd_pkg::REQ_RUN || req_type == dd_pkg::REQ_CLEAR),
        !in_ready)

    `DD_ASSERT_NOW(a_unreached_zero, clk, rst_n, out_valid && !all_reached, longest_distance == 20'd0)

    `DD_ASSERT_NOW(a_dist_range, clk, rst_n, out_valid, longest_distance < dd_pkg::NO_EDGE)

endmodule

bind dense_dijkstra_shortest_paths_top dd_checker u_dd_checker (.*);

// ----- bench/dense_dijkstra_shortest_paths_top_tb.sv -----
module dense_dijkstra_shortest_paths_top_tb;

    localparam int GRAPH_NODES  = 64;
    localparam int CLEAR_CYCLES = GRAPH_NODES * GRAPH_NODES + 128;
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = 20000000;

    typedef struct packed {
        logic        reached;
        logic [19:0] longest;
    } path_result_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  req;
        logic [5:0]  a;
        logic [5:0]  b;
        logic [15:0] w;
        logic [6:0]  nodes;
        logic        typed;
        logic        exp_reached;
        logic [19:0] exp_longest;
    } dir_row_t;

    localparam int DIR_ROWS = 28;
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd0,   1'b1, 1'b1, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd63, 6'd0,  16'd0,     7'd0,   1'b1, 1'b1, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_MARK,     6'd5,  6'd0,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd0,   1'b1, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_ADD_EDGE, 6'd0,  6'd5,  16'd65535, 7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd0,   1'b1, 1'b1, 20'd65535},
        '{ROW_WORD, dd_pkg::REQ_ADD_EDGE, 6'd5,  6'd0,  16'd100,   7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_ADD_EDGE, 6'd0,  6'd5,  16'd200,   7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd5,  6'd0,  16'd0,     7'd0,   1'b1, 1'b1, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd0,   1'b1, 1'b1, 20'd100},
        '{ROW_WORD, dd_pkg::REQ_ADD_EDGE, 6'd0,  6'd0,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_ADD_EDGE, 6'd5,  6'd63, 16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_MARK,     6'd63, 6'd0,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_CFG,  dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd10,  1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd0,   1'b1, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd12, 6'd0,  16'd0,     7'd0,   1'b1, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_CLEAR,    6'd0,  6'd0,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd12, 6'd0,  16'd0,     7'd0,   1'b1, 1'b1, 20'd0},
        '{ROW_CFG,  dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_MARK,     6'd0,  6'd0,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd0,   1'b1, 1'b1, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_ADD_EDGE, 6'd0,  6'd1,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_MARK,     6'd1,  6'd0,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd0,   1'b1, 1'b0, 20'd0},
        '{ROW_CFG,  dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd127, 1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_RUN,      6'd0,  6'd0,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0},
        '{ROW_WORD, dd_pkg::REQ_CLEAR,    6'd0,  6'd0,  16'd0,     7'd0,   1'b0, 1'b0, 20'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [5:0]  node_a;
    logic [5:0]  node_b;
    logic [15:0] weight;
    logic        out_valid;
    logic        out_ready;
    logic        all_reached;
    logic [19:0] longest_distance;

    dense_dijkstra_shortest_paths_top #(.MAX_NODES(GRAPH_NODES)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .node_a           (node_a),
        .node_b           (node_b),
        .weight           (weight),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .all_reached      (all_reached),
        .longest_distance (longest_distance)
    );

    always #6 clk = ~clk;

    // shadow graph
    logic [19:0]  graph_w [0:GRAPH_NODES*GRAPH_NODES-1];
    logic         graph_tgt [0:GRAPH_NODES-1];
    logic [6:0]   graph_nodes;
    logic [19:0]  sp_dist [0:GRAPH_NODES-1];
    logic         sp_seen [0:GRAPH_NODES-1];

    path_result_t expected_paths [$];
    path_result_t oldest_path;
    int           errors = 0;
    int           accepted = 0;
    int           settle_cycles = CLEAR_CYCLES;
    int           cycle_count = 0;
    logic         calm = 1'b0;
    logic         hold_off = 1'b0;

    // Update the shadow graph; return 1 with the search outcome for a run word.
    function automatic logic apply_to_graph(input logic [1:0] rq, input logic [5:0] a,
                                            input logic [5:0] b, input logic [15:0] w,
                                            output path_result_t res);
        int unsigned n;
        int unsigned cur;
        int unsigned nxt;
        int unsigned best;
        int unsigned sum;
        int          i;
        int          j;
        bit          found;
        res = '{1'b1, 20'd0};
        case (rq)
            dd_pkg::REQ_ADD_EDGE:
            begin
                if (graph_w[{a, b}] > 20'(w)) begin
                    graph_w[{a, b}] = 20'(w);
                    graph_w[{b, a}] = 20'(w);
                end
                return 1'b0;
            end
            dd_pkg::REQ_MARK:
            begin
                graph_tgt[a] = 1'b1;
                return 1'b0;
            end
            dd_pkg::REQ_CLEAR:
            begin
                for (i = 0; i < GRAPH_NODES * GRAPH_NODES; i++)
                    graph_w[i] = dd_pkg::NO_EDGE;
                for (i = 0; i < GRAPH_NODES; i++)
                    graph_tgt[i] = 1'b0;
                return 1'b0;
            end
            default:
            begin
                if (graph_nodes == 7'd0)
                    n = 1;
                else if (graph_nodes > 7'(GRAPH_NODES))
                    n = GRAPH_NODES;
                else
                    n = graph_nodes;
                for (j = 0; j < GRAPH_NODES; j++)
                begin
                    sp_dist[j] = dd_pkg::NO_EDGE;
                    sp_seen[j] = 1'b0;
                end
                if (a < n)
                begin
                    sp_dist[a] = 20'd0;
                    cur = a;
                    found = 1'b1;
                    while (found)
                    begin
                        sp_seen[cur] = 1'b1;
                        for (j = 0; j < n; j++)
                        begin
                            sum = sp_dist[cur] + graph_w[cur * GRAPH_NODES + j];
                            if (sum < sp_dist[j])
                                sp_dist[j] = 20'(sum);
                        end
                        found = 1'b0;
                        best = dd_pkg::NO_EDGE;
                        nxt = 0;
                        // lowest index wins a tie
                        for (j = 0; j < n; j++)
                        begin
                            if (!sp_seen[j] && sp_dist[j] < best)
                            begin
                                best = sp_dist[j];
                                nxt = j;
                                found = 1'b1;
                            end
                        end
                        cur = nxt;
                    end
                end
                for (i = 0; i < GRAPH_NODES; i++)
                begin
                    if (graph_tgt[i])
                    begin
                        if (!sp_seen[i])
                        begin
                            res = '{1'b0, 20'd0};
                            break;
                        end
                        if (sp_dist[i] > res.longest)
                            res.longest = sp_dist[i];
                    end
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic logic [5:0] pick_node(input int span);
        if ($urandom_range(9) == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, span - 1));
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd65535;
            2, 3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 60));
        endcase
    endfunction

    task automatic send_word(input logic [1:0] rq, input logic [5:0] a, input logic [5:0] b,
                             input logic [15:0] w, input logic typed,
                             input path_result_t fixed);
        path_result_t got;
        @(negedge clk);
        if (!calm)
        begin
            while ($urandom_range(99) < 9)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        req_type <= rq;
        node_a   <= a;
        node_b   <= b;
        weight   <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accepted++;
        if (apply_to_graph(rq, a, b, w, got))
        begin
            expected_paths.push_back(typed ? fixed : got);
            settle_cycles = 0;
        end
        else
            settle_cycles += (rq == dd_pkg::REQ_CLEAR) ? CLEAR_CYCLES : 8;
    endtask

    task automatic drain_paths();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_paths.size() != 0)
            @(negedge clk);
    endtask

    // Write only once the block has gone quiet.
    task automatic write_node_count(input logic [6:0] value);
        drain_paths();
        repeat (settle_cycles + 16) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        graph_nodes = value;
        settle_cycles = 0;
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            out_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_paths.size() == 0)
            begin
                errors++;
                if (errors < 50)
                    $display("%0t: unexpected word all_reached=%0d longest_distance=%0d",
                             $time, all_reached, longest_distance);
            end
            else
            begin
                oldest_path = expected_paths.pop_front();
                if (all_reached !== oldest_path.reached)
                begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: all_reached expected %0d got %0d",
                                 $time, oldest_path.reached, all_reached);
                end
                if (longest_distance !== oldest_path.longest)
                begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: longest_distance expected %0d got %0d",
                                 $time, oldest_path.longest, longest_distance);
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("dense_dijkstra_shortest_paths_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        int          p;
        int          k;
        int          span;
        int          quota;
        int          r;
        bit          paused;
        logic [6:0]  nodes;
        dir_row_t    row;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 7'd0;
        in_valid  = 1'b0;
        req_type  = dd_pkg::REQ_ADD_EDGE;
        node_a    = 6'd0;
        node_b    = 6'd0;
        weight    = 16'd0;
        paused    = 1'b0;
        for (r = 0; r < GRAPH_NODES * GRAPH_NODES; r++)
            graph_w[r] = dd_pkg::NO_EDGE;
        for (r = 0; r < GRAPH_NODES; r++)
            graph_tgt[r] = 1'b0;
        graph_nodes = dd_pkg::NODE_COUNT_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_CFG)
                write_node_count(row.nodes);
            else
                send_word(row.req, row.a, row.b, row.w, row.typed,
                          '{row.exp_reached, row.exp_longest});
        end

        for (p = 0; p < 10; p++)
        begin
            case (p)
                1: nodes = 7'd1;
                3: nodes = 7'd64;
                7: nodes = 7'd100;
                default: nodes = 7'($urandom_range(2, 12));
            endcase
            calm = 1'b0;
            write_node_count(nodes);
            span = (nodes >= 7'd64) ? GRAPH_NODES : int'(nodes);
            quota = accepted + ((nodes >= 7'd64) ? 40 : 230);
            calm = (p == 5);
            if (p == 2)
                hold_off = 1'b1;
            while (accepted < quota)
            begin
                if ($urandom_range(99) < 20)
                    send_word(dd_pkg::REQ_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom),
                              1'b0, '0);
                k = $urandom_range(3, 12);
                repeat (k)
                    send_word(dd_pkg::REQ_ADD_EDGE, pick_node(span), pick_node(span),
                              pick_weight(), 1'b0, '0);
                repeat ($urandom_range(0, 2))
                    send_word(dd_pkg::REQ_MARK, pick_node(span), 6'($urandom), 16'($urandom),
                              1'b0, '0);
                repeat ($urandom_range(1, 2))
                    send_word(dd_pkg::REQ_RUN, pick_node(span), 6'($urandom), 16'($urandom),
                              1'b0, '0);
                // noise: any word at all
                if ($urandom_range(99) < 10)
                    send_word(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom),
                              16'($urandom), 1'b0, '0);
                if (p == 4 && !paused && accepted > quota - 115)
                begin
                    drain_paths();
                    paused = 1'b1;
                end
            end
        end
        calm = 1'b0;

        drain_paths();
        repeat (settle_cycles + 64) @(negedge clk);
        if (errors == 0)
            $display("dense_dijkstra_shortest_paths_top_tb: PASS");
        else
            $display("dense_dijkstra_shortest_paths_top_tb: FAIL");
        $finish;
    end

endmodule
